### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the leading silence detector.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define LSD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define LSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lsd_pkg.sv
// ---------------------------------------------------------------------------
// lsd_pkg
// Widths, codes, configuration type and helpers of the leading silence
// detector.
// ---------------------------------------------------------------------------
package lsd_pkg;

    localparam int KIND_W      = 2;
    localparam int DATA_W      = 32;
    localparam int FRAME_W     = 20;
    localparam int FMT_W       = 3;
    localparam int CHCNT_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int MAG_W       = 32;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_IDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EFF_W        = CH_IDX_W + 1;

    localparam logic [MAG_W-1:0] FULL_SCALE = 32'h8000_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_END     = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    typedef enum logic [FMT_W-1:0] {
        FMT_U8  = 3'd0,
        FMT_S16 = 3'd1,
        FMT_S24 = 3'd2,
        FMT_S32 = 3'd3,
        FMT_F32 = 3'd4
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT    = 2'd0,
        CFG_CHANNELS  = 2'd1,
        CFG_LIMIT     = 2'd2,
        CFG_THRESHOLD = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [FMT_W-1:0]   sample_format;
        logic [CHCNT_W-1:0] channel_count;
        logic [FRAME_W-1:0] scan_limit;
        logic [MAG_W-1:0]   threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sample_format: 3'd1,
        channel_count: 4'd2,
        scan_limit:    20'd12000,
        threshold:     32'd6871948
    };

    // Channel count as used by the frame logic: zero counts as one, and the
    // count is capped at the channel capacity.
    function automatic logic [EFF_W-1:0] eff_channels(input logic [CHCNT_W-1:0] cc);
        logic [EFF_W-1:0] res;
        if (cc == '0)
        begin
            res = EFF_W'(1);
        end
        else if (32'(cc) > 32'(MAX_CHANNELS))
        begin
            res = EFF_W'(MAX_CHANNELS);
        end
        else
        begin
            res = EFF_W'(cc);
        end
        return res;
    endfunction

endpackage

### src/leading_silence_detector.sv
// ---------------------------------------------------------------------------
// leading_silence_detector
// Finds the first frame of a PCM clip that holds a sample at or above the
// loudness threshold; answers once per clip.
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    kind, sample_data
//  out      out_valid / out_stall  leading_frames, found
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat is taken every cycle while in_stall is low; a beat passes through
// the input register, then its result through the result register to out_valid.
// The decode, the threshold compare and the counter update share one cycle.
// A stalled result holds the pipe; an empty input register takes one more beat.
// Reset clears the counters, the decision and all valid flags and loads the
// default configuration; cfg_ready is always high.
// ---------------------------------------------------------------------------
module leading_silence_detector (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lsd_pkg::KIND_W-1:0]     kind,
    input  logic [lsd_pkg::DATA_W-1:0]     sample_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lsd_pkg::FRAME_W-1:0]    leading_frames,
    output logic                           found,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsd_pkg::DATA_W-1:0]     cfg_data
);
    import lsd_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [DATA_W-1:0] data_reg;
    logic              advance;
    logic              loud;
    logic              in_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FORMAT:    cfg_reg.sample_format <= cfg_data[FMT_W-1:0];
                CFG_CHANNELS:  cfg_reg.channel_count <= cfg_data[CHCNT_W-1:0];
                CFG_LIMIT:     cfg_reg.scan_limit    <= cfg_data[FRAME_W-1:0];
                CFG_THRESHOLD: cfg_reg.threshold     <= cfg_data[MAG_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            data_reg <= sample_data;
        end
    end

    lsd_mag u_mag (
        .sample_format (cfg_reg.sample_format),
        .sample_data   (data_reg),
        .threshold     (cfg_reg.threshold),
        .loud          (loud)
    );

    lsd_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .p_valid        (in_valid_reg),
        .p_kind         (kind_reg),
        .p_loud         (loud),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .leading_frames (leading_frames),
        .found          (found)
    );

endmodule

### src/lsd_mag.sv
// ---------------------------------------------------------------------------
// lsd_mag
// Decodes one raw sample to a Q31 magnitude and compares it with the
// loudness threshold.
// ---------------------------------------------------------------------------
module lsd_mag (
    input  logic [lsd_pkg::FMT_W-1:0]  sample_format,
    input  logic [lsd_pkg::DATA_W-1:0] sample_data,
    input  logic [lsd_pkg::MAG_W-1:0]  threshold,
    output logic                       loud
);
    import lsd_pkg::*;

    logic [7:0]       u8_byte;
    logic [7:0]       u8_abs;
    logic [15:0]      s16_abs;
    logic [23:0]      s24_abs;
    logic [31:0]      s32_abs;
    logic [7:0]       f_exp;
    logic [23:0]      f_man;
    logic [7:0]       f_up;
    logic [7:0]       f_dn;
    logic [MAG_W-1:0] f_mag;
    logic [MAG_W-1:0] mag;

    always_comb
    begin
        u8_byte = sample_data[7:0];
        u8_abs  = u8_byte[7] ? (u8_byte - 8'd128) : (8'd128 - u8_byte);
        s16_abs = sample_data[15] ? (~sample_data[15:0] + 16'd1) : sample_data[15:0];
        s24_abs = sample_data[23] ? (~sample_data[23:0] + 24'd1) : sample_data[23:0];
        s32_abs = sample_data[31] ? (~sample_data[31:0] + 32'd1) : sample_data[31:0];
    end

    // Float to Q31 by truncation: exponent 127 and up saturates, NaN and
    // subnormals read as silence, infinity as full scale.
    always_comb
    begin
        f_exp = sample_data[30:23];
        f_man = {1'b1, sample_data[22:0]};
        f_up  = f_exp - 8'd119;
        f_dn  = 8'd119 - f_exp;
        if (f_exp == 8'hFF)
        begin
            f_mag = (sample_data[22:0] != '0) ? '0 : FULL_SCALE;
        end
        else if (f_exp == 8'h00)
        begin
            f_mag = '0;
        end
        else if (f_exp >= 8'd127)
        begin
            f_mag = FULL_SCALE;
        end
        else if (f_exp >= 8'd119)
        begin
            f_mag = {8'b0, f_man} << f_up[2:0];
        end
        else if (f_dn >= 8'd24)
        begin
            f_mag = '0;
        end
        else
        begin
            f_mag = {8'b0, f_man} >> f_dn[4:0];
        end
    end

    always_comb
    begin
        case (fmt_t'(sample_format))
            FMT_U8:  mag = {u8_abs, 24'b0};
            FMT_S16: mag = {s16_abs, 16'b0};
            FMT_S24: mag = {s24_abs, 8'b0};
            FMT_S32: mag = s32_abs;
            FMT_F32: mag = f_mag;
            default: mag = FULL_SCALE;
        endcase
    end

    assign loud = (mag >= threshold);

endmodule

### src/lsd_scan.sv
// ---------------------------------------------------------------------------
// lsd_scan
// Frame and channel counters, the per-clip decision and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lsd_scan (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsd_pkg::cfg_t                cfg,
    input  logic                         p_valid,
    input  logic [lsd_pkg::KIND_W-1:0]   p_kind,
    input  logic                         p_loud,
    output logic                         advance,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lsd_pkg::FRAME_W-1:0]  leading_frames,
    output logic                         found
);
    import lsd_pkg::*;

    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [CH_IDX_W-1:0] chan_reg, chan_next;
    logic                decided_reg, decided_next;
    logic                out_valid_reg;
    logic [FRAME_W-1:0]  frames_reg;
    logic                found_reg;

    logic                emit;
    logic [FRAME_W-1:0]  res_frames;
    logic                res_found;
    logic [FRAME_W-1:0]  frame_inc;
    logic [EFF_W-1:0]    chan_inc;
    logic [EFF_W-1:0]    eff;

    // The item moves on when the result register is empty or being taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign frame_inc = frame_reg + 1'b1;
    assign chan_inc  = {1'b0, chan_reg} + 1'b1;
    assign eff       = eff_channels(cfg.channel_count);

    always_comb
    begin
        frame_next   = frame_reg;
        chan_next    = chan_reg;
        decided_next = decided_reg;
        emit         = 1'b0;
        res_frames   = '0;
        res_found    = 1'b0;
        if (advance && p_valid)
        begin
            case (kind_t'(p_kind))
                KIND_RESTART:
                begin
                    frame_next   = '0;
                    chan_next    = '0;
                    decided_next = 1'b0;
                    if (cfg.scan_limit == '0)
                    begin
                        emit         = 1'b1;
                        decided_next = 1'b1;
                    end
                end
                KIND_END:
                begin
                    if (!decided_reg)
                    begin
                        emit         = 1'b1;
                        decided_next = 1'b1;
                    end
                end
                KIND_SAMPLE:
                begin
                    if (!decided_reg)
                    begin
                        if (frame_reg >= cfg.scan_limit)
                        begin
                            emit         = 1'b1;
                            decided_next = 1'b1;
                        end
                        else if (p_loud)
                        begin
                            emit         = 1'b1;
                            res_frames   = frame_reg;
                            res_found    = 1'b1;
                            decided_next = 1'b1;
                        end
                        else if (chan_inc >= eff)
                        begin
                            chan_next  = '0;
                            frame_next = frame_inc;
                            if (frame_inc >= cfg.scan_limit)
                            begin
                                emit         = 1'b1;
                                decided_next = 1'b1;
                            end
                        end
                        else
                        begin
                            chan_next = chan_inc[CH_IDX_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            chan_reg      <= '0;
            decided_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg   <= frame_next;
            chan_reg    <= chan_next;
            decided_reg <= decided_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            frames_reg <= res_frames;
            found_reg  <= res_found;
        end
    end

    assign out_valid      = out_valid_reg;
    assign leading_frames = frames_reg;
    assign found          = found_reg;

    `LSD_ASSERT_NEXT(a_emit_decides, emit, decided_reg, "result given without closing the clip")
    `LSD_ASSERT_ALWAYS(a_silent_zero, !out_valid_reg || found_reg || frames_reg == '0,
        "silent answer with nonzero frame count")
    `LSD_ASSERT_ALWAYS(a_frame_step,
        $stable(frame_reg) || frame_reg == '0 || frame_reg == $past(frame_reg) + 1'b1,
        "frame counter moved by more than one frame")
    `LSD_ASSERT_NEXT(a_hold_result, out_valid_reg && out_stall,
        out_valid_reg && $stable(frames_reg) && $stable(found_reg),
        "stalled result changed")

endmodule
